@@ design/sequence_loss_tracker_defines.svh @@
// Assertion macros shared by the sequence loss tracker RTL.
// No dependencies; expects clk and arst_n in the including module.
`ifndef SEQUENCE_LOSS_TRACKER_DEFINES_SVH
`define SEQUENCE_LOSS_TRACKER_DEFINES_SVH

// checked only while out of reset
`define SLT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked during reset as well
`define SLT_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/slt_pkg.sv @@
// Types and constants for the sequence loss tracker.
// No dependencies; used by sequence_loss_tracker.
package slt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SEQ_W       = 16;
	localparam int CNT_OUT_W   = 10;

	localparam logic ACT_MESSAGE   = 1'b0;
	localparam logic ACT_LINK_LOST = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic             action;
		logic [SEQ_W-1:0] seq_number;
	} in_req_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] received_count;
		logic [CNT_OUT_W-1:0] lost_count;
		logic                 late_flag;
		logic                 range_error;
	} out_req_t;

endpackage

@@ design/slt_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module slt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ design/sequence_loss_tracker.sv @@
// Sequence loss tracker top level: counter, mark table RAM and scan sequencer.
// Depends on slt_pkg, slt_ram and sequence_loss_tracker_defines.svh.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------
//  input   | in_valid  | in_stall  | in_data  (in_req_t)
//  output  | out_valid | out_stall | out_data (out_req_t)
//
// A message request runs mark write, one RAM read per entry below the counter, drain,
// finish and idle; count 0 skips scan and drain, and finish waits while a held result stalls.
// When the counter wraps, a clear sweep of all TABLE_DEPTH entries is added.
// After reset all TABLE_DEPTH table entries are swept clear; in_stall is high.
// A link-lost request completes in its accept cycle and gives no result.
// One result register: the next request runs while a result waits on out_stall.
`include "sequence_loss_tracker_defines.svh"

module sequence_loss_tracker
	import slt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output out_req_t out_data
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CLEAR  = 6'b000010,
		ST_MARK   = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t           state_q;
	addr_t            cnt_q;
	logic             started_q;
	addr_t            clr_q;
	addr_t            scan_q;
	logic             item_q;
	logic             rd_pend_q;
	addr_t            lost_q;
	logic [SEQ_W-1:0] seq_q;
	logic             late_q;
	logic             rerr_q;
	logic             out_valid_q;
	out_req_t         out_q;

	logic             ram_we;
	addr_t            ram_addr;
	logic             ram_wdata;
	logic             ram_rdata;

	logic             accept;
	logic [ADDR_W:0]  cnt_adv;
	logic             wrap;
	logic             seq_in_range;
	logic             fin_go;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cnt_adv      = started_q ? ((ADDR_W+1)'(cnt_q) + (ADDR_W+1)'(1)) : '0;
	assign wrap         = (cnt_adv == (ADDR_W+1)'(TABLE_DEPTH));
	assign seq_in_range = (32'(seq_q) < 32'(TABLE_DEPTH));
	assign fin_go       = (state_q == ST_FINISH) && !(out_valid_q && out_stall);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = 1'b0;
		ram_addr  = scan_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_MARK: begin
				ram_we    = seq_in_range;
				ram_wdata = 1'b1;
				ram_addr  = seq_q[ADDR_W-1:0];
			end
			default: begin
				ram_addr = scan_q;
			end
		endcase
	end

	slt_ram #(
		.WIDTH(1),
		.DEPTH(TABLE_DEPTH)
	) u_marks (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			clr_q       <= '0;
			scan_q      <= '0;
			item_q      <= 1'b0;
			rd_pend_q   <= 1'b0;
			lost_q      <= '0;
			late_q      <= 1'b0;
			rerr_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= 1'b0;
			if (rd_pend_q) begin
				lost_q <= lost_q + {{(ADDR_W-1){1'b0}}, ~ram_rdata};
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.action == ACT_LINK_LOST) begin
							started_q <= 1'b0;
							cnt_q     <= '0;
						end else begin
							started_q <= 1'b1;
							cnt_q     <= wrap ? '0 : cnt_adv[ADDR_W-1:0];
							lost_q    <= '0;
							scan_q    <= '0;
							clr_q     <= '0;
							item_q    <= 1'b1;
							state_q   <= wrap ? ST_CLEAR : ST_MARK;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + addr_t'(1);
					if (clr_q == addr_t'(TABLE_DEPTH - 1)) begin
						state_q <= item_q ? ST_MARK : ST_IDLE;
					end
				end
				ST_MARK: begin
					rerr_q  <= !seq_in_range;
					late_q  <= seq_in_range && (32'(seq_q) < 32'(cnt_q));
					state_q <= (cnt_q == '0) ? ST_FINISH : ST_SCAN;
				end
				ST_SCAN: begin
					rd_pend_q <= 1'b1;
					scan_q    <= scan_q + addr_t'(1);
					if (scan_q == cnt_q - addr_t'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						item_q      <= 1'b0;
						if (late_q && (cnt_q != '0)) begin
							cnt_q <= cnt_q - addr_t'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded once per message request
	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q.received_count <= CNT_OUT_W'(cnt_q);
			out_q.lost_count     <= CNT_OUT_W'(lost_q);
			out_q.late_flag      <= late_q;
			out_q.range_error    <= rerr_q;
		end
	end

	// the item being scanned holds its seq number
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= in_data.seq_number;
		end
	end

	`SLT_ASSERT_ALWAYS(a_reset_clears, !arst_n |=> state_q == ST_CLEAR, "table clear must follow reset")
	`SLT_ASSERT(a_no_write_in_scan, (state_q == ST_SCAN || state_q == ST_DRAIN) |-> !ram_we, "mark table written during scan")
	`SLT_ASSERT(a_read_in_scan, rd_pend_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN), "scan read data outside scan")
	`SLT_ASSERT(a_lost_bounded, state_q == ST_FINISH |-> lost_q <= cnt_q, "lost count above counter")

endmodule
